[rtl/core/fps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_pkg
// Types and constants shared by the frame pacing statistics block.
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int BUCKETS   = 8;
    localparam int BUCKET_W  = 3;
    localparam int TS_W      = 48;
    localparam int TICK_W    = 32;
    localparam int OUT_CNT_W = 32;
    localparam int WIN_W     = 16;

    // window length in microseconds fits 65535 * 1000
    localparam int WIN_US_W  = 26;

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_DROP = 1'b1;

    localparam int US_PER_MS = 1000;

    localparam logic [WIN_US_W-1:0] WIN_RESET_US = WIN_US_W'(1000 * US_PER_MS);

    // upper whole-ms bounds of the coarse buckets and of the last exact one
    localparam int B5_LAST_MS = 7;
    localparam int B6_LAST_MS = 15;
    localparam int EXACT_LAST_MS = 4;

    localparam logic [BUCKET_W-1:0] BKT_SUB_MS = 3'd0;
    localparam logic [BUCKET_W-1:0] BKT_5_7    = 3'd5;
    localparam logic [BUCKET_W-1:0] BKT_8_15   = 3'd6;
    localparam logic [BUCKET_W-1:0] BKT_LONG   = 3'd7;

    typedef struct packed {
        logic              command;
        logic [TICK_W-1:0] tick_id;
        logic [TS_W-1:0]   timestamp_us;
    } t_in_item;

    typedef struct packed {
        logic [BUCKET_W-1:0]  bucket_index;
        logic [OUT_CNT_W-1:0] bucket_count;
        logic [OUT_CNT_W-1:0] drawn_frames;
        logic [OUT_CNT_W-1:0] dropped_frames;
        logic [OUT_CNT_W-1:0] ticks_closed;
        logic [OUT_CNT_W-1:0] longest_drop_run;
        logic [OUT_CNT_W-1:0] fewest_per_tick;
        logic [OUT_CNT_W-1:0] most_per_tick;
        logic                 last_of_report;
    } t_out_item;

endpackage

[rtl/core/frame_pacing_stats_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_pacing_stats_top
// Frame pacing statistics over report windows.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries drawn and
// dropped frame events. A transaction lands in an input register and is
// folded into the statistics from there, so events stream at one per
// cycle while no report drains. The output channel (o_out_valid /
// i_out_ready / o_out_data) carries reports of eight items, one per gap
// bucket; the first item is valid from the clock edge that folds in the
// event closing the window. While a report drains, event processing
// pauses and the input register holds at most one waiting event; a stalled
// receiver simply stretches that pause. Report totals and the histogram
// clear when the eighth item is taken.
// i_cfg_we / i_cfg_wdata write the window length in ms; it is kept as a
// microsecond threshold. Synchronous reset restores a 1000 ms window and
// clears all statistics; no clearing pass is needed.
// ----------------------------------------------------------------------------
module frame_pacing_stats_top #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  fps_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output fps_pkg::t_out_item          o_out_data,
    input  logic                        i_cfg_we,
    input  logic [fps_pkg::WIN_W-1:0]   i_cfg_wdata
);

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    function automatic logic [COUNTER_BITS-1:0] f_sat_inc(input logic [COUNTER_BITS-1:0] v);
        f_sat_inc = (v == CNT_MAX) ? v : v + COUNTER_BITS'(1);
    endfunction

    // input register
    logic                     r_in_valid;
    fps_pkg::t_in_item        r_in;

    // configuration
    logic [fps_pkg::WIN_US_W-1:0] r_window_us;

    // tracking state
    logic                          r_tick_open, n_tick_open;
    logic [fps_pkg::TICK_W-1:0]    r_open_tick, n_open_tick;
    logic [COUNTER_BITS-1:0]       r_ft, n_ft;
    logic                          r_win_started, n_win_started;
    logic [fps_pkg::TS_W-1:0]      r_start, n_start;
    logic                          r_have_last, n_have_last;
    logic [fps_pkg::TS_W-1:0]      r_last, n_last;
    logic [COUNTER_BITS-1:0]       r_drop_run, n_drop_run;

    // report state
    logic [COUNTER_BITS-1:0]       r_drawn, n_drawn;
    logic [COUNTER_BITS-1:0]       r_dropped, n_dropped;
    logic [COUNTER_BITS-1:0]       r_tt, n_tt;
    logic [COUNTER_BITS-1:0]       r_longest, n_longest;
    logic [COUNTER_BITS-1:0]       r_fewest, n_fewest;
    logic [COUNTER_BITS-1:0]       r_most, n_most;
    logic [COUNTER_BITS-1:0]       r_hist [fps_pkg::BUCKETS];
    logic [COUNTER_BITS-1:0]       n_hist [fps_pkg::BUCKETS];

    // report emitter
    logic                          r_busy;
    logic [fps_pkg::BUCKET_W-1:0]  r_idx;

    logic                          w_proc;
    logic                          w_out_fire;
    logic                          w_out_last;
    logic                          w_new_tick;
    logic                          w_close;
    logic [COUNTER_BITS-1:0]       w_ft_base;
    logic [fps_pkg::TS_W-1:0]      w_start;
    logic [fps_pkg::TS_W:0]        w_el_diff;
    logic [fps_pkg::TS_W-1:0]      w_elapsed;
    logic                          w_report;
    logic [fps_pkg::BUCKET_W-1:0]  w_bucket;

    assign w_proc     = r_in_valid && !r_busy;
    assign o_in_ready = !r_in_valid || w_proc;
    assign w_out_last = (r_idx == fps_pkg::BUCKET_W'(fps_pkg::BUCKETS - 1));
    assign w_out_fire = r_busy && i_out_ready;

    fps_gap_bin u_gap_bin (
        .i_now    (r_in.timestamp_us),
        .i_last   (r_last),
        .o_bucket (w_bucket)
    );

    assign w_new_tick = !(r_tick_open && (r_open_tick == r_in.tick_id));
    assign w_close    = w_new_tick && r_tick_open;
    assign w_ft_base  = w_new_tick ? '0 : r_ft;

    // window start of an unstarted window is this frame, giving zero elapsed
    assign w_start   = r_win_started ? r_start : r_in.timestamp_us;
    assign w_el_diff = {1'b0, r_in.timestamp_us} - {1'b0, w_start};
    assign w_elapsed = w_el_diff[fps_pkg::TS_W] ? '0 : w_el_diff[fps_pkg::TS_W-1:0];
    assign w_report  = (r_in.command == fps_pkg::CMD_DRAW)
                    && (w_elapsed >= fps_pkg::TS_W'(r_window_us));

    always_comb begin
        n_win_started = r_win_started;
        n_start       = r_start;
        n_have_last   = r_have_last;
        n_last        = r_last;
        n_drop_run    = r_drop_run;
        n_drawn       = r_drawn;
        n_dropped     = r_dropped;
        n_longest     = r_longest;
        n_hist        = r_hist;

        // tick bookkeeping
        n_tick_open = 1'b1;
        n_open_tick = r_in.tick_id;
        n_ft        = w_ft_base;
        n_tt        = w_close ? f_sat_inc(r_tt) : r_tt;
        n_most      = (w_close && (r_ft > r_most)) ? r_ft : r_most;
        n_fewest    = (w_close && ((r_tt == '0) || (r_ft < r_fewest))) ? r_ft : r_fewest;

        if (r_in.command == fps_pkg::CMD_DROP) begin
            n_drop_run = f_sat_inc(r_drop_run);
            n_dropped  = f_sat_inc(r_dropped);
            if (n_drop_run > r_longest) begin
                n_longest = n_drop_run;
            end
        end else begin
            n_win_started = 1'b1;
            n_start       = w_report ? r_in.timestamp_us : w_start;
            if (r_have_last) begin
                n_hist[w_bucket] = f_sat_inc(r_hist[w_bucket]);
            end
            n_have_last = 1'b1;
            n_last      = r_in.timestamp_us;
            n_drop_run  = '0;
            n_ft        = f_sat_inc(w_ft_base);
            n_drawn     = f_sat_inc(r_drawn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_window_us   <= fps_pkg::WIN_RESET_US;
            r_tick_open   <= 1'b0;
            r_open_tick   <= '0;
            r_ft          <= '0;
            r_win_started <= 1'b0;
            r_start       <= '0;
            r_have_last   <= 1'b0;
            r_last        <= '0;
            r_drop_run    <= '0;
            r_drawn       <= '0;
            r_dropped     <= '0;
            r_tt          <= '0;
            r_longest     <= '0;
            r_fewest      <= '0;
            r_most        <= '0;
            for (int i = 0; i < fps_pkg::BUCKETS; i++) begin
                r_hist[i] <= '0;
            end
            r_busy        <= 1'b0;
            r_idx         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window_us <= fps_pkg::WIN_US_W'(i_cfg_wdata)
                             * fps_pkg::WIN_US_W'(fps_pkg::US_PER_MS);
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_proc) begin
                r_tick_open   <= n_tick_open;
                r_open_tick   <= n_open_tick;
                r_ft          <= n_ft;
                r_win_started <= n_win_started;
                r_start       <= n_start;
                r_have_last   <= n_have_last;
                r_last        <= n_last;
                r_drop_run    <= n_drop_run;
                r_drawn       <= n_drawn;
                r_dropped     <= n_dropped;
                r_tt          <= n_tt;
                r_longest     <= n_longest;
                r_fewest      <= n_fewest;
                r_most        <= n_most;
                r_hist        <= n_hist;
                if (w_report) begin
                    r_busy <= 1'b1;
                    r_idx  <= '0;
                end
            end
            // report reads live totals; they clear once the last item goes out
            if (w_out_fire) begin
                r_idx <= r_idx + fps_pkg::BUCKET_W'(1);
                if (w_out_last) begin
                    r_busy    <= 1'b0;
                    r_drawn   <= '0;
                    r_dropped <= '0;
                    r_tt      <= '0;
                    r_longest <= '0;
                    r_fewest  <= '0;
                    r_most    <= '0;
                    for (int i = 0; i < fps_pkg::BUCKETS; i++) begin
                        r_hist[i] <= '0;
                    end
                end
            end
        end
    end

    assign o_out_valid                   = r_busy;
    assign o_out_data.bucket_index       = r_idx;
    assign o_out_data.bucket_count       = fps_pkg::OUT_CNT_W'(r_hist[r_idx]);
    assign o_out_data.drawn_frames       = fps_pkg::OUT_CNT_W'(r_drawn);
    assign o_out_data.dropped_frames     = fps_pkg::OUT_CNT_W'(r_dropped);
    assign o_out_data.ticks_closed       = fps_pkg::OUT_CNT_W'(r_tt);
    assign o_out_data.longest_drop_run   = fps_pkg::OUT_CNT_W'(r_longest);
    assign o_out_data.fewest_per_tick    = fps_pkg::OUT_CNT_W'(r_fewest);
    assign o_out_data.most_per_tick      = fps_pkg::OUT_CNT_W'(r_most);
    assign o_out_data.last_of_report     = w_out_last;

endmodule

[rtl/core/fps_gap_bin.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_gap_bin
// Classifies the gap between two draw timestamps into a histogram bucket.
// ----------------------------------------------------------------------------
module fps_gap_bin (
    input  logic [fps_pkg::TS_W-1:0]     i_now,
    input  logic [fps_pkg::TS_W-1:0]     i_last,
    output logic [fps_pkg::BUCKET_W-1:0] o_bucket
);

    localparam logic [fps_pkg::TS_W-1:0] T1 = fps_pkg::TS_W'(fps_pkg::US_PER_MS);
    localparam logic [fps_pkg::TS_W-1:0] T2 = fps_pkg::TS_W'(2 * fps_pkg::US_PER_MS);
    localparam logic [fps_pkg::TS_W-1:0] T3 = fps_pkg::TS_W'(3 * fps_pkg::US_PER_MS);
    localparam logic [fps_pkg::TS_W-1:0] T4 = fps_pkg::TS_W'(
        fps_pkg::EXACT_LAST_MS * fps_pkg::US_PER_MS);
    localparam logic [fps_pkg::TS_W-1:0] T5 = fps_pkg::TS_W'(
        (fps_pkg::EXACT_LAST_MS + 1) * fps_pkg::US_PER_MS);
    localparam logic [fps_pkg::TS_W-1:0] T8 = fps_pkg::TS_W'(
        (fps_pkg::B5_LAST_MS + 1) * fps_pkg::US_PER_MS);
    localparam logic [fps_pkg::TS_W-1:0] T16 = fps_pkg::TS_W'(
        (fps_pkg::B6_LAST_MS + 1) * fps_pkg::US_PER_MS);

    logic [fps_pkg::TS_W:0]   w_diff;
    logic [fps_pkg::TS_W-1:0] w_gap;

    // clock going backwards counts as zero gap
    assign w_diff = {1'b0, i_now} - {1'b0, i_last};
    assign w_gap  = w_diff[fps_pkg::TS_W] ? '0 : w_diff[fps_pkg::TS_W-1:0];

    always_comb begin
        if (w_gap < T1) begin
            o_bucket = fps_pkg::BKT_SUB_MS;
        end else if (w_gap < T2) begin
            o_bucket = 3'd1;
        end else if (w_gap < T3) begin
            o_bucket = 3'd2;
        end else if (w_gap < T4) begin
            o_bucket = 3'd3;
        end else if (w_gap < T5) begin
            o_bucket = 3'd4;
        end else if (w_gap < T8) begin
            o_bucket = fps_pkg::BKT_5_7;
        end else if (w_gap < T16) begin
            o_bucket = fps_pkg::BKT_8_15;
        end else begin
            o_bucket = fps_pkg::BKT_LONG;
        end
    end

endmodule

[rtl/core/fps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_checker
// Port-level checks on report sequencing of the frame pacing statistics block.
// ----------------------------------------------------------------------------
module fps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input fps_pkg::t_out_item o_out_data
);

    localparam logic [fps_pkg::BUCKET_W-1:0] LAST_IDX =
        fps_pkg::BUCKET_W'(fps_pkg::BUCKETS - 1);

    // a stalled result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last_of_report == (o_out_data.bucket_index == LAST_IDX)))
        else $error("last_of_report not on final bucket");

    // a report's eight items come without a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_of_report |=> o_out_valid)
        else $error("report interrupted");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last_of_report
        |=> o_out_data.bucket_index
            == $past(o_out_data.bucket_index) + fps_pkg::BUCKET_W'(1))
        else $error("bucket index did not advance");

endmodule

bind frame_pacing_stats_top fps_checker u_fps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[tb/sv/tb_frame_pacing_stats_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_pacing_stats_top
// Self-checking bench for the frame pacing statistics block. A short script of
// frame events with hand-computed reports covers the gap buckets, window edges,
// clock steps backwards and the window register extremes. Random event streams
// follow under three handshake idling mixes and one long output stall. Every
// report item is compared with an expected item, from the hand-computed rows or from a transaction-level model.
// ----------------------------------------------------------------------------
module tb_frame_pacing_stats_top;
    import fps_pkg::*;

    localparam int LIMIT_CYCLES     = 400_000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_CYCLES      = 150;
    localparam int RANDOM_PER_PHASE = 35;
    localparam int N_DIRECTED       = 28;

    typedef logic [OUT_CNT_W-1:0] t_count;

    typedef struct packed {
        logic             is_cfg;
        logic [WIN_W-1:0] win;
        t_in_item         ev;
        logic             rep;
        t_count           drawn;
        t_count           dropped;
        t_count           ticks;
        t_count           longest;
        t_count           fewest;
        t_count           most;
        logic [0:7][7:0]  hist;
    } t_script_row;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_item         in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_item        out_data;
    logic             cfg_we    = 1'b0;
    logic [WIN_W-1:0] cfg_wdata = '0;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_asked  = 0;
    int unsigned hold_seen   = 0;
    int unsigned hold_left   = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches  = 0;

    t_out_item   pending_reports[$];
    t_out_item   want;
    t_script_row directed_rows[N_DIRECTED];

    // model state
    logic [WIN_W-1:0]  win_ms;
    logic              cur_open;
    logic [TICK_W-1:0] cur_tick;
    t_count            cur_frames;
    logic              win_live;
    logic [TS_W-1:0]   win_start_us;
    logic              seen_draw;
    logic [TS_W-1:0]   prev_draw_us;
    t_count            drop_streak;
    t_count            sum_drawn, sum_dropped, sum_ticks;
    t_count            sum_longest, sum_fewest, sum_most;
    t_count            gap_bins[BUCKETS];

    // random stream state
    logic [TICK_W-1:0] stim_tick;
    logic [TS_W-1:0]   stim_now;

    frame_pacing_stats_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    function automatic t_count bump(input t_count v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic t_script_row evt(input logic cmd, input logic [TICK_W-1:0] tick,
                                        input logic [TS_W-1:0] ts);
        t_script_row r;
        r = '0;
        r.ev.command      = cmd;
        r.ev.tick_id      = tick;
        r.ev.timestamp_us = ts;
        return r;
    endfunction

    function automatic t_script_row rpt(input logic cmd, input logic [TICK_W-1:0] tick,
                                        input logic [TS_W-1:0] ts, input t_count drawn,
                                        input t_count dropped, input t_count ticks,
                                        input t_count longest, input t_count fewest,
                                        input t_count most, input logic [0:7][7:0] hist);
        t_script_row r;
        r = evt(cmd, tick, ts);
        r.rep     = 1'b1;
        r.drawn   = drawn;
        r.dropped = dropped;
        r.ticks   = ticks;
        r.longest = longest;
        r.fewest  = fewest;
        r.most    = most;
        r.hist    = hist;
        return r;
    endfunction

    function automatic t_script_row cfg_row(input logic [WIN_W-1:0] ms);
        t_script_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.win    = ms;
        return r;
    endfunction

    // appends one expected report item at the tail of the queue
    task automatic add_expected(input t_out_item exp_item);
        pending_reports.insert(pending_reports.size(), exp_item);
    endtask

    // folds one accepted event into the statistics, queues a report when the window closes
    task automatic account_frame_event(input t_in_item ev);
        logic [TS_W-1:0]     gap_us;
        logic [TS_W-1:0]     gap_ms;
        logic [TS_W-1:0]     run_ms;
        logic [BUCKET_W-1:0] bin;
        t_out_item           r;
        if (!cur_open || cur_tick != ev.tick_id) begin
            if (cur_open) begin
                if (sum_ticks == 0 || cur_frames < sum_fewest) sum_fewest = cur_frames;
                if (cur_frames > sum_most) sum_most = cur_frames;
                sum_ticks = bump(sum_ticks);
            end
            cur_open   = 1'b1;
            cur_tick   = ev.tick_id;
            cur_frames = '0;
        end
        if (ev.command == CMD_DROP) begin
            drop_streak = bump(drop_streak);
            sum_dropped = bump(sum_dropped);
            if (drop_streak > sum_longest) sum_longest = drop_streak;
            return;
        end
        if (!win_live) begin
            win_live     = 1'b1;
            win_start_us = ev.timestamp_us;
        end
        if (seen_draw) begin
            gap_us = (ev.timestamp_us >= prev_draw_us) ? ev.timestamp_us - prev_draw_us : '0;
            gap_ms = gap_us / US_PER_MS;
            if (gap_ms > B6_LAST_MS) bin = BKT_LONG;
            else if (gap_ms > B5_LAST_MS) bin = BKT_8_15;
            else if (gap_ms > EXACT_LAST_MS) bin = BKT_5_7;
            else if (gap_ms == 0) bin = BKT_SUB_MS;
            else bin = BUCKET_W'(gap_ms);
            gap_bins[bin] = bump(gap_bins[bin]);
        end
        seen_draw    = 1'b1;
        prev_draw_us = ev.timestamp_us;
        drop_streak  = '0;
        cur_frames   = bump(cur_frames);
        sum_drawn    = bump(sum_drawn);
        run_ms = (ev.timestamp_us >= win_start_us) ?
                 (ev.timestamp_us - win_start_us) / US_PER_MS : '0;
        if (run_ms < TS_W'(win_ms)) return;
        for (int k = 0; k < BUCKETS; k++) begin
            r.bucket_index     = BUCKET_W'(k);
            r.bucket_count     = gap_bins[k];
            r.drawn_frames     = sum_drawn;
            r.dropped_frames   = sum_dropped;
            r.ticks_closed     = sum_ticks;
            r.longest_drop_run = sum_longest;
            r.fewest_per_tick  = sum_fewest;
            r.most_per_tick    = sum_most;
            r.last_of_report   = (k == BUCKETS - 1);
            add_expected(r);
            gap_bins[k] = '0;
        end
        sum_drawn    = '0;
        sum_dropped  = '0;
        sum_ticks    = '0;
        sum_longest  = '0;
        sum_fewest   = '0;
        sum_most     = '0;
        win_start_us = ev.timestamp_us;
    endtask

    task automatic send_item(input t_in_item ev);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // drop valid, let every report drain, then give the input register time to empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window_ms(input logic [WIN_W-1:0] ms);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ms;
        @(negedge clk);
        cfg_we <= 1'b0;
        win_ms = ms;
    endtask

    // mostly a steady stream with bucket-spread gaps, some noise and clock steps back
    task automatic make_random_event(output t_in_item ev);
        int unsigned roll;
        int unsigned gap_ms;
        roll = $urandom_range(99);
        ev.tick_id      = stim_tick;
        ev.timestamp_us = stim_now;
        if (roll < 80) begin
            if ($urandom_range(3) == 0) stim_tick = stim_tick + 1'b1;
            ev.tick_id = stim_tick;
            ev.command = ($urandom_range(3) == 0) ? CMD_DROP : CMD_DRAW;
            if (ev.command == CMD_DRAW) begin
                gap_ms = ($urandom_range(9) == 0) ? $urandom_range(16, 200) : $urandom_range(17);
                stim_now = stim_now + TS_W'(gap_ms * US_PER_MS + $urandom_range(999));
                ev.timestamp_us = stim_now;
            end else begin
                ev.timestamp_us = TS_W'({$urandom, $urandom});
            end
        end else if (roll < 90) begin
            ev.command      = CMD_DROP;
            ev.tick_id      = $urandom;
            ev.timestamp_us = TS_W'({$urandom, $urandom});
        end else begin
            ev.command      = CMD_DRAW;
            ev.tick_id      = $urandom_range(1) ? stim_tick : TICK_W'($urandom);
            ev.timestamp_us = stim_now - TS_W'($urandom_range(20000));
        end
    endtask

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_reports.size() == 0) begin
                $error("report item with nothing expected: %p", out_data);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                if (out_data.bucket_index !== want.bucket_index) begin
                    $error("bucket_index expected %0d got %0d",
                           want.bucket_index, out_data.bucket_index);
                    mismatches++;
                end
                if (out_data.bucket_count !== want.bucket_count) begin
                    $error("bucket_count expected %0d got %0d",
                           want.bucket_count, out_data.bucket_count);
                    mismatches++;
                end
                if (out_data.drawn_frames !== want.drawn_frames) begin
                    $error("drawn_frames expected %0d got %0d",
                           want.drawn_frames, out_data.drawn_frames);
                    mismatches++;
                end
                if (out_data.dropped_frames !== want.dropped_frames) begin
                    $error("dropped_frames expected %0d got %0d",
                           want.dropped_frames, out_data.dropped_frames);
                    mismatches++;
                end
                if (out_data.ticks_closed !== want.ticks_closed) begin
                    $error("ticks_closed expected %0d got %0d",
                           want.ticks_closed, out_data.ticks_closed);
                    mismatches++;
                end
                if (out_data.longest_drop_run !== want.longest_drop_run) begin
                    $error("longest_drop_run expected %0d got %0d",
                           want.longest_drop_run, out_data.longest_drop_run);
                    mismatches++;
                end
                if (out_data.fewest_per_tick !== want.fewest_per_tick) begin
                    $error("fewest_per_tick expected %0d got %0d",
                           want.fewest_per_tick, out_data.fewest_per_tick);
                    mismatches++;
                end
                if (out_data.most_per_tick !== want.most_per_tick) begin
                    $error("most_per_tick expected %0d got %0d",
                           want.most_per_tick, out_data.most_per_tick);
                    mismatches++;
                end
                if (out_data.last_of_report !== want.last_of_report) begin
                    $error("last_of_report expected %0d got %0d",
                           want.last_of_report, out_data.last_of_report);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_script_row row;
        t_in_item    ev;
        t_out_item   r;
        int unsigned depth;
        int unsigned phase_win;

        win_ms       = WIN_W'(1000);
        cur_open     = 1'b0;
        cur_tick     = '0;
        cur_frames   = '0;
        win_live     = 1'b0;
        win_start_us = '0;
        seen_draw    = 1'b0;
        prev_draw_us = '0;
        drop_streak  = '0;
        sum_drawn    = '0;
        sum_dropped  = '0;
        sum_ticks    = '0;
        sum_longest  = '0;
        sum_fewest   = '0;
        sum_most     = '0;
        foreach (gap_bins[k]) gap_bins[k] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset window of 1000 ms first, then 1 ms, zero and the maximum
        directed_rows = '{
            evt(CMD_DRAW, 5, 0),
            evt(CMD_DRAW, 5, 500),
            evt(CMD_DROP, 5, 48'hFFFF_FFFF_FFFF),
            evt(CMD_DROP, 6, 0),
            evt(CMD_DRAW, 6, 1500),
            evt(CMD_DRAW, 7, 3500),
            evt(CMD_DRAW, 7, 6500),
            evt(CMD_DRAW, 7, 10500),
            evt(CMD_DRAW, 7, 17499),
            evt(CMD_DRAW, 7, 33498),
            evt(CMD_DRAW, 7, 49498),
            evt(CMD_DRAW, 7, 100),
            evt(CMD_DRAW, 7, 999_999),
            rpt(CMD_DRAW, 8, 1_000_000, 12, 2, 3, 2, 1, 8,
                {8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2}),
            evt(CMD_DRAW, 8, 5),
            cfg_row(1),
            evt(CMD_DRAW, 8, 1004),
            rpt(CMD_DRAW, 9, 1_001_000, 3, 0, 1, 0, 3, 3,
                {8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1}),
            cfg_row(0),
            evt(CMD_DROP, 9, 0),
            rpt(CMD_DRAW, 9, 1_001_000, 1, 1, 0, 1, 0, 0,
                {8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}),
            cfg_row(16'hFFFF),
            evt(CMD_DRAW, 9, 66_535_999),
            rpt(CMD_DRAW, 32'hFFFF_FFFF, 66_536_000, 2, 0, 1, 0, 3, 3,
                {8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1}),
            rpt(CMD_DRAW, 0, 48'hFFFF_FFFF_FFFF, 1, 0, 1, 0, 1, 1,
                {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1}),
            evt(CMD_DRAW, 0, 0),
            cfg_row(0),
            rpt(CMD_DRAW, 0, 0, 2, 0, 0, 0, 0, 0,
                {8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0})
        };

        tx_idle_pct = 14;
        rx_idle_pct = 85;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                settle();
                set_window_ms(row.win);
            end else begin
                send_item(row.ev);
                depth = pending_reports.size();
                account_frame_event(row.ev);
                if (row.rep) begin
                    // hand-computed report takes the place of the modeled one
                    while (pending_reports.size() > depth) void'(pending_reports.pop_back());
                    for (int k = 0; k < BUCKETS; k++) begin
                        r.bucket_index     = BUCKET_W'(k);
                        r.bucket_count     = t_count'(row.hist[k]);
                        r.drawn_frames     = row.drawn;
                        r.dropped_frames   = row.dropped;
                        r.ticks_closed     = row.ticks;
                        r.longest_drop_run = row.longest;
                        r.fewest_per_tick  = row.fewest;
                        r.most_per_tick    = row.most;
                        r.last_of_report   = (k == BUCKETS - 1);
                        add_expected(r);
                    end
                end
            end
        end

        stim_tick = $urandom;
        stim_now  = 48'h0000_4000_0000 + TS_W'($urandom);
        for (int phase = 0; phase < 3; phase++) begin
            settle();
            case (phase)
                0: begin
                    phase_win   = $urandom_range(10, 40);
                    tx_idle_pct = 14;
                    rx_idle_pct = 85;
                end
                1: begin
                    phase_win   = $urandom_range(1, 8);
                    tx_idle_pct = 85;
                    rx_idle_pct = 14;
                end
                default: begin
                    // short window and a stalled receiver back up the block
                    phase_win   = 1;
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_asked++;
                end
            endcase
            set_window_ms(WIN_W'(phase_win));
            repeat (RANDOM_PER_PHASE) begin
                make_random_event(ev);
                send_item(ev);
                account_frame_event(ev);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
